// ===== rtl/core/ghws_pkg.sv =====
// ============================================================================
// ghws_pkg: shared types and constants for the gated polynomial weight shift
// Widths, fixed-point constants, polynomial coefficients and register codes.
// ============================================================================
package ghws_pkg;

    // Field widths
    localparam int unsigned ENERGY_W = 24;
    localparam int unsigned W_W      = 40;
    localparam int unsigned SIG_W    = 32;
    localparam int unsigned BEAM_W   = 2;

    // Fixed-point formats
    localparam int unsigned E_FRAC = 16;
    localparam int unsigned W_FRAC = 24;
    localparam int unsigned C_FRAC = 40;

    localparam int unsigned POLY_DEGREE_DEF = 8;

    // Energies inside the window stay below 2^20, so the multiplier sees 20 bits.
    localparam int unsigned E_W = 20;

    // Horner accumulator: 40 fractional bits plus headroom for every degree
    // from one to twelve over the energy window.
    localparam int unsigned ACC_W = 54;
    localparam int unsigned SPLIT = ACC_W / 2;

    // Shift factor products.
    localparam int unsigned PD_W = ACC_W + SIG_W;
    localparam int unsigned T_W  = PD_W - C_FRAC;
    localparam int unsigned F_W  = T_W + 1;
    localparam int unsigned R_W  = 64;

    localparam logic signed [ACC_W-1:0] ONE_ACC = ACC_W'(1) << C_FRAC;
    localparam logic signed [F_W-1:0]   F_ONE   = F_W'(1) << W_FRAC;

    localparam logic signed [W_W-1:0] W_MAX = {1'b0, {(W_W-1){1'b1}}};
    localparam logic signed [W_W-1:0] W_MIN = {1'b1, {(W_W-1){1'b0}}};

    // Gating thresholds
    localparam logic [ENERGY_W-1:0]     E_LOW     = ENERGY_W'(81920);
    localparam logic [ENERGY_W-1:0]     E_HIGH    = ENERGY_W'(655360);
    localparam logic signed [SIG_W-1:0] SIGMA_MIN = SIG_W'(168);

    // Beam mode codes
    localparam logic [BEAM_W-1:0] BEAM_FWD  = 2'd0;
    localparam logic [BEAM_W-1:0] BEAM_REV  = 2'd1;
    localparam logic [BEAM_W-1:0] BEAM_BOTH = 2'd2;

    // Configuration port
    localparam int unsigned PADDR_W   = 3;
    localparam int unsigned PDATA_W   = 32;
    localparam int unsigned REG_IDX_W = 1;
    localparam logic [REG_IDX_W-1:0] REG_BEAM_MODE = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_SIGMA     = 1'b1;

    // Data that rides along with each request through the pipeline.
    typedef struct packed {
        logic                  apply;
        logic signed [W_W-1:0] w;
    } t_side;

    // Polynomial coefficients with 40 fractional bits, rounded to nearest.
    function automatic logic signed [ACC_W-1:0] coef(input int unsigned idx);
        logic signed [ACC_W-1:0] c;
        case (idx)
            0:       c = ACC_W'(64'sd2592208613645);
            1:       c = ACC_W'(-64'sd4559652730155);
            2:       c = ACC_W'(64'sd5094971956370);
            3:       c = ACC_W'(-64'sd2697058042469);
            4:       c = ACC_W'(64'sd766468456211);
            5:       c = ACC_W'(-64'sd124021613078);
            6:       c = ACC_W'(64'sd11450973799);
            7:       c = ACC_W'(-64'sd561874631);
            8:       c = ACC_W'(64'sd11369280);
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/core/ghws_cfg.sv =====
// ============================================================================
// ghws_cfg: configuration registers
// APB-style register file holding the beam mode and the signed shift size.
// ============================================================================
module ghws_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ghws_pkg::PADDR_W-1:0]       paddr,
    input  logic [ghws_pkg::PDATA_W-1:0]       pwdata,
    output logic [ghws_pkg::PDATA_W-1:0]       prdata,
    output logic                               pready,
    output logic [ghws_pkg::BEAM_W-1:0]        o_beam_mode,
    output logic signed [ghws_pkg::SIG_W-1:0]  o_sigma_shift
);

    logic [ghws_pkg::BEAM_W-1:0]       r_beam_mode;
    logic signed [ghws_pkg::SIG_W-1:0] r_sigma;
    logic [ghws_pkg::REG_IDX_W-1:0]    reg_idx;
    logic                              wr_en;

    assign reg_idx = paddr[ghws_pkg::PADDR_W-1:ghws_pkg::PADDR_W-ghws_pkg::REG_IDX_W];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beam_mode <= ghws_pkg::BEAM_BOTH;
            r_sigma     <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                ghws_pkg::REG_BEAM_MODE: r_beam_mode <= pwdata[ghws_pkg::BEAM_W-1:0];
                ghws_pkg::REG_SIGMA:     r_sigma     <= $signed(pwdata[ghws_pkg::SIG_W-1:0]);
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            ghws_pkg::REG_BEAM_MODE: prdata = ghws_pkg::PDATA_W'(r_beam_mode);
            ghws_pkg::REG_SIGMA:     prdata = ghws_pkg::PDATA_W'(r_sigma);
            default:                 prdata = '0;
        endcase
    end

    assign o_beam_mode   = r_beam_mode;
    assign o_sigma_shift = r_sigma;

endmodule

// ===== rtl/core/ghws_horner_stage.sv =====
// ============================================================================
// ghws_horner_stage: one Horner step
// Multiplies the accumulator by the energy, drops 16 fractional bits (floor)
// and adds the next coefficient, then registers the result.
// ============================================================================
module ghws_horner_stage #(
    parameter int unsigned COEF_IDX = 0
) (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic signed [ghws_pkg::ACC_W-1:0]  i_acc,
    input  logic [ghws_pkg::E_W-1:0]           i_energy,
    input  ghws_pkg::t_side                    i_side,
    output logic signed [ghws_pkg::ACC_W-1:0]  o_acc,
    output logic [ghws_pkg::E_W-1:0]           o_energy,
    output ghws_pkg::t_side                    o_side
);

    localparam logic signed [ghws_pkg::ACC_W-1:0] COEF = ghws_pkg::coef(COEF_IDX);

    logic signed [ghws_pkg::ACC_W+ghws_pkg::E_W:0] prod;
    logic signed [ghws_pkg::ACC_W-1:0]             n_acc;
    logic signed [ghws_pkg::ACC_W-1:0]             r_acc;
    logic [ghws_pkg::E_W-1:0]                      r_energy;
    ghws_pkg::t_side                               r_side;

    assign prod  = i_acc * $signed({1'b0, i_energy});
    // An arithmetic right shift of the product is the floor of the quotient.
    assign n_acc = $signed(prod[ghws_pkg::ACC_W+ghws_pkg::E_FRAC-1:ghws_pkg::E_FRAC]) + COEF;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_acc    <= n_acc;
            r_energy <= i_energy;
            r_side   <= i_side;
        end
    end

    assign o_acc    = r_acc;
    assign o_energy = r_energy;
    assign o_side   = r_side;

endmodule

// ===== rtl/core/ghws_factor.sv =====
// ============================================================================
// ghws_factor: shift factor
// Forms f = floor((p(E) - 1) * sigma / 2^40) + 2^24 over two stages, with the
// wide product cut into two partial products.
// ============================================================================
module ghws_factor (
    input  logic                               i_clk,
    input  logic                               i_en_a,
    input  logic                               i_en_b,
    input  logic signed [ghws_pkg::ACC_W-1:0]  i_acc,
    input  logic signed [ghws_pkg::SIG_W-1:0]  i_sigma,
    input  ghws_pkg::t_side                    i_side,
    output logic signed [ghws_pkg::F_W-1:0]    o_f,
    output ghws_pkg::t_side                    o_side
);

    localparam int unsigned PLO_W = ghws_pkg::SIG_W + ghws_pkg::SPLIT + 1;
    localparam int unsigned PHI_W = ghws_pkg::SIG_W + ghws_pkg::ACC_W - ghws_pkg::SPLIT;

    logic signed [ghws_pkg::ACC_W-1:0] d;
    logic signed [PLO_W-1:0]           n_p_lo;
    logic signed [PHI_W-1:0]           n_p_hi;
    logic signed [PLO_W-1:0]           r_p_lo;
    logic signed [PHI_W-1:0]           r_p_hi;
    ghws_pkg::t_side                   r_side_a;

    logic signed [ghws_pkg::PD_W-1:0]  sum_d;
    logic signed [ghws_pkg::T_W-1:0]   t;
    logic signed [ghws_pkg::F_W-1:0]   n_f;
    logic signed [ghws_pkg::F_W-1:0]   r_f;
    ghws_pkg::t_side                   r_side_b;

    // Stage A: split the difference into a low unsigned half and a signed high half.
    assign d      = i_acc - ghws_pkg::ONE_ACC;
    assign n_p_lo = i_sigma * $signed({1'b0, d[ghws_pkg::SPLIT-1:0]});
    assign n_p_hi = i_sigma * $signed(d[ghws_pkg::ACC_W-1:ghws_pkg::SPLIT]);

    always_ff @(posedge i_clk) begin
        if (i_en_a) begin
            r_p_lo   <= n_p_lo;
            r_p_hi   <= n_p_hi;
            r_side_a <= i_side;
        end
    end

    // Stage B: recombine, floor to 24 fractional bits and add one.
    assign sum_d = (ghws_pkg::PD_W'(r_p_hi) <<< ghws_pkg::SPLIT) + ghws_pkg::PD_W'(r_p_lo);
    assign t     = sum_d[ghws_pkg::PD_W-1:ghws_pkg::C_FRAC];
    assign n_f   = ghws_pkg::F_W'(t) + ghws_pkg::F_ONE;

    always_ff @(posedge i_clk) begin
        if (i_en_b) begin
            r_f      <= n_f;
            r_side_b <= r_side_a;
        end
    end

    assign o_f    = r_f;
    assign o_side = r_side_b;

endmodule

// ===== rtl/core/ghws_apply.sv =====
// ============================================================================
// ghws_apply: weight scaling and output register
// Multiplies selected weights by the factor in two partial products, floors to
// 24 fractional bits, saturates, passes others through and holds the result.
// ============================================================================
module ghws_apply (
    input  logic                                i_clk,
    input  logic                                i_en_c,
    input  logic                                i_en_d,
    input  logic signed [ghws_pkg::F_W-1:0]     i_f,
    input  ghws_pkg::t_side                     i_side,
    output logic signed [ghws_pkg::W_W-1:0]     o_weight_out,
    output logic                                o_was_applied,
    output logic                                o_saturated
);

    localparam int unsigned QLO_W = ghws_pkg::W_W + ghws_pkg::W_FRAC + 1;
    localparam int unsigned QHI_W = ghws_pkg::W_W + ghws_pkg::F_W - ghws_pkg::W_FRAC;

    localparam logic signed [ghws_pkg::R_W-1:0] R_MAX = ghws_pkg::R_W'(ghws_pkg::W_MAX);
    localparam logic signed [ghws_pkg::R_W-1:0] R_MIN = ghws_pkg::R_W'(ghws_pkg::W_MIN);

    logic signed [QLO_W-1:0]          n_q_lo;
    logic signed [QHI_W-1:0]          n_q_hi;
    logic signed [QLO_W-1:0]          r_q_lo;
    logic signed [QHI_W-1:0]          r_q_hi;
    ghws_pkg::t_side                  r_side;

    logic signed [ghws_pkg::R_W-1:0]  prod_r;
    logic                             over_hi;
    logic                             over_lo;
    logic signed [ghws_pkg::W_W-1:0]  n_weight;
    logic                             n_sat;
    logic signed [ghws_pkg::W_W-1:0]  r_weight;
    logic                             r_applied;
    logic                             r_sat;

    // Stage C
    assign n_q_lo = i_side.w * $signed({1'b0, i_f[ghws_pkg::W_FRAC-1:0]});
    assign n_q_hi = i_side.w * $signed(i_f[ghws_pkg::F_W-1:ghws_pkg::W_FRAC]);

    always_ff @(posedge i_clk) begin
        if (i_en_c) begin
            r_q_lo <= n_q_lo;
            r_q_hi <= n_q_hi;
            r_side <= i_side;
        end
    end

    // Stage D: the high partial already sits at the output scale.
    assign prod_r  = ghws_pkg::R_W'(r_q_hi) + ghws_pkg::R_W'(r_q_lo >>> ghws_pkg::W_FRAC);
    assign over_hi = prod_r > R_MAX;
    assign over_lo = prod_r < R_MIN;

    always_comb begin
        n_weight = prod_r[ghws_pkg::W_W-1:0];
        n_sat    = 1'b0;
        if (!r_side.apply) begin
            n_weight = r_side.w;
        end else if (over_hi) begin
            n_weight = ghws_pkg::W_MAX;
            n_sat    = 1'b1;
        end else if (over_lo) begin
            n_weight = ghws_pkg::W_MIN;
            n_sat    = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en_d) begin
            r_weight  <= n_weight;
            r_applied <= r_side.apply;
            r_sat     <= n_sat;
        end
    end

    assign o_weight_out  = r_weight;
    assign o_was_applied = r_applied;
    assign o_saturated   = r_sat;

endmodule

// ===== rtl/core/gated_polynomial_weight_shift.sv =====
// ============================================================================
// gated_polynomial_weight_shift: gated polynomial weight shift
// Scales event weights by (p(E) - 1) * sigma + 1 for selected events, with p
// a fixed polynomial evaluated by Horner's rule in a pipeline.
// ============================================================================
// Throughput: one request per cycle while the output is not stalled; one
// stage per Horner step, two for the shift factor and two for the weight
// product and saturation. Empty stages load while the output is stalled,
// so bubbles close up. Reset (synchronous, active low) empties the pipeline
// and sets beam mode to both polarities and the shift size to zero.
module gated_polynomial_weight_shift #(
    parameter int unsigned POLY_DEGREE = ghws_pkg::POLY_DEGREE_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [ghws_pkg::ENERGY_W-1:0]       i_energy,
    input  logic                                i_is_far_detector,
    input  logic                                i_is_forward_horn,
    input  logic signed [ghws_pkg::W_W-1:0]     i_weight_in,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [ghws_pkg::W_W-1:0]     o_weight_out,
    output logic                                o_was_applied,
    output logic                                o_saturated,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ghws_pkg::PADDR_W-1:0]        paddr,
    input  logic [ghws_pkg::PDATA_W-1:0]        pwdata,
    output logic [ghws_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready
);

    localparam int unsigned NS = POLY_DEGREE + 4;

    logic [ghws_pkg::BEAM_W-1:0]       beam_mode;
    logic signed [ghws_pkg::SIG_W-1:0] sigma;

    logic [NS-1:0] r_v;
    logic [NS-1:0] v_in;
    logic [NS:0]   en;

    logic sigma_big;
    logic beam_ok;
    logic energy_ok;
    logic apply;

    logic signed [ghws_pkg::ACC_W-1:0] acc_c    [0:POLY_DEGREE];
    logic [ghws_pkg::E_W-1:0]          energy_c [0:POLY_DEGREE];
    ghws_pkg::t_side                   side_c   [0:POLY_DEGREE];

    logic signed [ghws_pkg::F_W-1:0]   f;
    ghws_pkg::t_side                   side_f;

    ghws_cfg u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_beam_mode   (beam_mode),
        .o_sigma_shift (sigma)
    );

    // Gating decision, made as the request enters.
    assign sigma_big = (sigma >= ghws_pkg::SIGMA_MIN) || (sigma <= -ghws_pkg::SIGMA_MIN);
    assign beam_ok   = !((beam_mode == ghws_pkg::BEAM_FWD && !i_is_forward_horn) ||
                         (beam_mode == ghws_pkg::BEAM_REV && i_is_forward_horn));
    assign energy_ok = (i_energy >= ghws_pkg::E_LOW) && (i_energy <= ghws_pkg::E_HIGH);
    assign apply     = sigma_big && i_is_far_detector && beam_ok && energy_ok;

    // Stage enables: a stage moves when it is empty or its successor moves.
    assign en[NS] = !i_stall;
    for (genvar g = 0; g < NS; g++) begin : g_en
        assign en[g] = !r_v[g] || en[g+1];
    end

    assign v_in = {r_v[NS-2:0], i_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (en[k]) begin
                    r_v[k] <= v_in[k];
                end
            end
        end
    end

    assign o_stall = !en[0];
    assign o_valid = r_v[NS-1];

    assign acc_c[0]    = ghws_pkg::coef(POLY_DEGREE);
    assign energy_c[0] = i_energy[ghws_pkg::E_W-1:0];
    assign side_c[0]   = '{apply: apply, w: i_weight_in};

    for (genvar g = 0; g < POLY_DEGREE; g++) begin : g_horner
        ghws_horner_stage #(
            .COEF_IDX (POLY_DEGREE - 1 - g)
        ) u_stage (
            .i_clk    (i_clk),
            .i_en     (en[g]),
            .i_acc    (acc_c[g]),
            .i_energy (energy_c[g]),
            .i_side   (side_c[g]),
            .o_acc    (acc_c[g+1]),
            .o_energy (energy_c[g+1]),
            .o_side   (side_c[g+1])
        );
    end

    ghws_factor u_factor (
        .i_clk   (i_clk),
        .i_en_a  (en[POLY_DEGREE]),
        .i_en_b  (en[POLY_DEGREE+1]),
        .i_acc   (acc_c[POLY_DEGREE]),
        .i_sigma (sigma),
        .i_side  (side_c[POLY_DEGREE]),
        .o_f     (f),
        .o_side  (side_f)
    );

    ghws_apply u_apply (
        .i_clk         (i_clk),
        .i_en_c        (en[POLY_DEGREE+2]),
        .i_en_d        (en[POLY_DEGREE+3]),
        .i_f           (f),
        .i_side        (side_f),
        .o_weight_out  (o_weight_out),
        .o_was_applied (o_was_applied),
        .o_saturated   (o_saturated)
    );

endmodule

// ===== rtl/core/ghws_checker.sv =====
// ============================================================================
// ghws_checker: port-level checks
// Watches the top-level ports for reset, stall and saturation behavior.
// ============================================================================
module ghws_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                o_stall,
    input logic                                o_valid,
    input logic                                i_stall,
    input logic signed [ghws_pkg::W_W-1:0]     o_weight_out,
    input logic                                o_was_applied,
    input logic                                o_saturated
);

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result offered right after reset");

    // The input side only backs up when every stage is full and the output is held.
    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled while the pipeline can still move");

    // A clipped result comes from an applied factor and sits at a range limit.
    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_saturated) |->
            (o_was_applied &&
             (o_weight_out == ghws_pkg::W_MAX || o_weight_out == ghws_pkg::W_MIN)))
        else $error("saturated result not at a range limit");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=>
            (o_valid && $stable(o_weight_out) && $stable(o_was_applied) &&
             $stable(o_saturated)))
        else $error("stalled result changed");

endmodule

bind gated_polynomial_weight_shift ghws_checker u_ghws_checker (.*);

// ===== sim/gated_polynomial_weight_shift_tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// gated_polynomial_weight_shift_tb: self-checking bench for the weight shift
// Sends event requests over the valid/stall channel, predicts each result
// with a bit-exact fixed-point model of the gating, the Horner polynomial and
// the saturating weight product, and compares every result in order. The run
// walks through several beam modes and shift sizes with random idling on both
// sides and one long output hold-off.
// ============================================================================
module gated_polynomial_weight_shift_tb;

    localparam int unsigned HORNER_DEG     = ghws_pkg::POLY_DEGREE_DEF;
    localparam int          NUM_PHASES     = 8;
    localparam int          PHASE_REQS     = 120;
    localparam int          PRESSURE_PHASE = 4;
    localparam int          HOLD_CYCLES    = 200;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          TAIL_CYCLES    = 20;
    // Unused code, acts as both.
    localparam logic [ghws_pkg::BEAM_W-1:0] BEAM_ALT = 2'd3;

    typedef struct {
        logic [ghws_pkg::ENERGY_W-1:0] energy;
        logic                          far;
        logic                          fwd;
        logic signed [ghws_pkg::W_W-1:0] weight;
    } t_shift_req;

    typedef struct {
        logic signed [ghws_pkg::W_W-1:0] weight;
        logic                            applied;
        logic                            clipped;
    } t_shift_res;

    class t_shift_scoreboard;
        logic [ghws_pkg::BEAM_W-1:0]       beam_mode;
        logic signed [ghws_pkg::SIG_W-1:0] sigma;
        longint                            coef_q40[HORNER_DEG+1];
        t_shift_res                        expected_q[$];
        int                                errors;
        int                                checked;
        int                                applied;
        int                                clipped;

        function new();
            beam_mode   = ghws_pkg::BEAM_BOTH;
            sigma       = '0;
            coef_q40[0] = to_q40(23576, 10000, 1'b0);
            coef_q40[1] = to_q40(414698, 100000, 1'b1);
            coef_q40[2] = to_q40(463385, 100000, 1'b0);
            coef_q40[3] = to_q40(245296, 100000, 1'b1);
            coef_q40[4] = to_q40(697099, 1000000, 1'b0);
            coef_q40[5] = to_q40(112797, 1000000, 1'b1);
            coef_q40[6] = to_q40(104146, 10000000, 1'b0);
            coef_q40[7] = to_q40(511022, 1000000000, 1'b1);
            coef_q40[8] = to_q40(103403, 64'd10000000000, 1'b0);
        endfunction

        // Decimal fraction to 40 fractional bits, rounded half away from zero.
        function longint to_q40(longint unsigned num, longint unsigned den, bit neg);
            logic [127:0] n;
            n = 128'(num);
            n = ((n << ghws_pkg::C_FRAC) + den / 2) / den;
            return neg ? -longint'(n[63:0]) : longint'(n[63:0]);
        endfunction

        // floor(a * b / 2^s) with the magnitude limited to 2^62.
        function longint mul_floor_shift(longint a, longint b, int unsigned s);
            logic signed [127:0] wa;
            logic signed [127:0] wb;
            logic signed [127:0] q;
            logic signed [127:0] lim;
            wa  = 128'(a);
            wb  = 128'(b);
            lim = 128'sd1 <<< 62;
            q   = (wa * wb) >>> s;
            if (q > lim) begin
                q = lim;
            end else if (q < -lim) begin
                q = -lim;
            end
            return longint'(q[63:0]);
        endfunction

        function void set_register(logic [ghws_pkg::REG_IDX_W-1:0] idx,
                                   logic [ghws_pkg::PDATA_W-1:0] value);
            if (idx == ghws_pkg::REG_BEAM_MODE) begin
                beam_mode = value[ghws_pkg::BEAM_W-1:0];
            end else if (idx == ghws_pkg::REG_SIGMA) begin
                sigma = value[ghws_pkg::SIG_W-1:0];
            end
        endfunction

        function t_shift_res predict(t_shift_req rq);
            t_shift_res res;
            longint     sg;
            longint     e;
            longint     acc;
            longint     t;
            longint     r;
            bit         pass_through;
            sg = longint'(sigma);
            e  = longint'(rq.energy);
            pass_through = (sg < longint'(ghws_pkg::SIGMA_MIN) &&
                            sg > -longint'(ghws_pkg::SIGMA_MIN))
                || !rq.far
                || (beam_mode == ghws_pkg::BEAM_FWD && !rq.fwd)
                || (beam_mode == ghws_pkg::BEAM_REV && rq.fwd)
                || rq.energy < ghws_pkg::E_LOW || rq.energy > ghws_pkg::E_HIGH;
            res.weight  = rq.weight;
            res.applied = 1'b0;
            res.clipped = 1'b0;
            if (!pass_through) begin
                acc = coef_q40[HORNER_DEG];
                for (int i = HORNER_DEG - 1; i >= 0; i--) begin
                    acc = mul_floor_shift(acc, e, ghws_pkg::E_FRAC) + coef_q40[i];
                end
                t = mul_floor_shift(acc - (64'sd1 <<< ghws_pkg::C_FRAC), sg,
                                    ghws_pkg::C_FRAC);
                r = mul_floor_shift(longint'(rq.weight), t + (64'sd1 <<< ghws_pkg::W_FRAC),
                                    ghws_pkg::W_FRAC);
                res.applied = 1'b1;
                if (r > longint'(ghws_pkg::W_MAX)) begin
                    r = longint'(ghws_pkg::W_MAX);
                    res.clipped = 1'b1;
                end else if (r < longint'(ghws_pkg::W_MIN)) begin
                    r = longint'(ghws_pkg::W_MIN);
                    res.clipped = 1'b1;
                end
                res.weight = r[ghws_pkg::W_W-1:0];
            end
            return res;
        endfunction

        function void note_request(t_shift_req rq);
            expected_q = {expected_q, predict(rq)};
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void check_result(logic signed [ghws_pkg::W_W-1:0] weight, logic applied_bit,
                                   logic clipped_bit);
            t_shift_res exp_res;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result weight=%0d applied=%b saturated=%b",
                         $time, weight, applied_bit, clipped_bit);
                errors++;
                return;
            end
            exp_res = expected_q.pop_front();
            checked++;
            if (exp_res.applied) applied++;
            if (exp_res.clipped) clipped++;
            if (weight !== exp_res.weight) begin
                $display("%0t: weight_out expected %0d actual %0d",
                         $time, exp_res.weight, weight);
                errors++;
            end
            if (applied_bit !== exp_res.applied) begin
                $display("%0t: was_applied expected %b actual %b",
                         $time, exp_res.applied, applied_bit);
                errors++;
            end
            if (clipped_bit !== exp_res.clipped) begin
                $display("%0t: saturated expected %b actual %b",
                         $time, exp_res.clipped, clipped_bit);
                errors++;
            end
        endfunction
    endclass

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_valid;
    logic                            o_stall;
    logic [ghws_pkg::ENERGY_W-1:0]   i_energy;
    logic                            i_is_far_detector;
    logic                            i_is_forward_horn;
    logic signed [ghws_pkg::W_W-1:0] i_weight_in;
    logic                            o_valid;
    logic                            i_stall;
    logic signed [ghws_pkg::W_W-1:0] o_weight_out;
    logic                            o_was_applied;
    logic                            o_saturated;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [ghws_pkg::PADDR_W-1:0]    paddr;
    logic [ghws_pkg::PDATA_W-1:0]    pwdata;
    logic [ghws_pkg::PDATA_W-1:0]    prdata;
    logic                            pready;

    t_shift_scoreboard sb = new();

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_len      = 0;
    int idle_cycles   = 0;
    int n_sent        = 0;
    int n_settings    = 0;

    gated_polynomial_weight_shift u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_energy          (i_energy),
        .i_is_far_detector (i_is_far_detector),
        .i_is_forward_horn (i_is_forward_horn),
        .i_weight_in       (i_weight_in),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_weight_out      (o_weight_out),
        .o_was_applied     (o_was_applied),
        .o_saturated       (o_saturated),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    always #4 i_clk = ~i_clk;

    // Output side: random stalls, or a counted hold-off when one is requested.
    always @(posedge i_clk) begin
        if (hold_len > 0) begin
            i_stall <= 1'b1;
            hold_len--;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_result(o_weight_out, o_was_applied, o_saturated);
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no progress for %0d cycles, %0d results outstanding",
                     $time, idle_cycles, sb.pending());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send_request(input t_shift_req rq);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid           <= 1'b1;
        i_energy          <= rq.energy;
        i_is_far_detector <= rq.far;
        i_is_forward_horn <= rq.fwd;
        i_weight_in       <= rq.weight;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_request(rq);
        n_sent++;
    endtask

    task automatic send_fields(input logic [ghws_pkg::ENERGY_W-1:0] energy, input logic far,
                               input logic fwd, input logic signed [ghws_pkg::W_W-1:0] weight);
        t_shift_req rq;
        rq.energy = energy;
        rq.far    = far;
        rq.fwd    = fwd;
        rq.weight = weight;
        send_request(rq);
    endtask

    // Registers only change once every outstanding request has come back.
    task automatic write_register(input logic [ghws_pkg::REG_IDX_W-1:0] idx,
                                  input logic [ghws_pkg::PDATA_W-1:0] value);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ghws_pkg::PADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_register(idx, value);
        n_settings++;
    endtask

    function automatic t_shift_req random_request();
        t_shift_req  rq;
        logic [63:0] r64;
        r64 = {$urandom, $urandom};
        case ($urandom_range(9))
            0: rq.energy = r64[ghws_pkg::ENERGY_W-1:0];
            1: begin
                case ($urandom_range(5))
                    0: rq.energy = ghws_pkg::E_LOW - 24'd1;
                    1: rq.energy = ghws_pkg::E_LOW;
                    2: rq.energy = ghws_pkg::E_LOW + 24'd1;
                    3: rq.energy = ghws_pkg::E_HIGH - 24'd1;
                    4: rq.energy = ghws_pkg::E_HIGH;
                    default: rq.energy = ghws_pkg::E_HIGH + 24'd1;
                endcase
            end
            default: rq.energy = ghws_pkg::ENERGY_W'($urandom_range(ghws_pkg::E_HIGH,
                                                                    ghws_pkg::E_LOW));
        endcase
        rq.far = ($urandom_range(9) != 0);
        rq.fwd = 1'($urandom_range(1));
        r64 = {$urandom, $urandom};
        case ($urandom_range(7))
            0: rq.weight = r64[ghws_pkg::W_W-1:0];
            1: begin
                case (r64[1:0])
                    2'd0: rq.weight = ghws_pkg::W_MAX;
                    2'd1: rq.weight = ghws_pkg::W_MIN;
                    2'd2: rq.weight = '0;
                    default: rq.weight = '1;
                endcase
            end
            2: rq.weight = {r64[ghws_pkg::W_W-1] ? 2'b01 : 2'b10, r64[ghws_pkg::W_W-3:0]};
            default: rq.weight = ghws_pkg::W_W'($signed(r64[31:0]));
        endcase
        return rq;
    endfunction

    logic [ghws_pkg::BEAM_W-1:0] phase_beam[NUM_PHASES] = '{
        ghws_pkg::BEAM_FWD, ghws_pkg::BEAM_REV, ghws_pkg::BEAM_BOTH, BEAM_ALT,
        ghws_pkg::BEAM_BOTH, ghws_pkg::BEAM_FWD, ghws_pkg::BEAM_REV, ghws_pkg::BEAM_BOTH};
    logic [ghws_pkg::PDATA_W-1:0] phase_sigma[NUM_PHASES] = '{32'h7FFF_FFFF, 32'h8000_0000,
                                                              32'd167, 32'hFFFF_FF58,
                                                              32'h0040_0000, 32'hFFFF_FF59,
                                                              32'h0000_0000, 32'd168};

    initial begin
        logic [ghws_pkg::PDATA_W-1:0] sig;
        i_clk             = 1'b0;
        i_rst_n           = 1'b0;
        i_valid           = 1'b0;
        i_stall           = 1'b0;
        i_energy          = '0;
        i_is_far_detector = 1'b0;
        i_is_forward_horn = 1'b0;
        i_weight_in       = '0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings leave the shift at zero, so these pass straight through.
        send_fields(ghws_pkg::E_LOW + 24'd1000, 1'b1, 1'b1, 40'sd16777216);
        send_fields(ghws_pkg::E_HIGH, 1'b1, 1'b0, ghws_pkg::W_MIN);

        write_register(ghws_pkg::REG_BEAM_MODE, ghws_pkg::PDATA_W'(ghws_pkg::BEAM_BOTH));
        write_register(ghws_pkg::REG_SIGMA, 32'h0100_0000);
        send_fields(ghws_pkg::E_LOW - 24'd1, 1'b1, 1'b1, 40'sd16777216);
        send_fields(ghws_pkg::E_LOW, 1'b1, 1'b1, 40'sd16777216);
        send_fields(ghws_pkg::E_HIGH, 1'b1, 1'b1, 40'sd16777216);
        send_fields(ghws_pkg::E_HIGH + 24'd1, 1'b1, 1'b1, 40'sd16777216);
        send_fields('0, 1'b1, 1'b1, 40'sd16777216);
        send_fields('1, 1'b1, 1'b1, 40'sd16777216);
        send_fields(ghws_pkg::E_LOW + 24'd5000, 1'b0, 1'b1, 40'sd16777216);
        send_fields(ghws_pkg::E_LOW + 24'd5000, 1'b1, 1'b0, -40'sd33554432);
        send_fields(ghws_pkg::E_HIGH - 24'd7, 1'b1, 1'b1, ghws_pkg::W_MAX);
        send_fields(ghws_pkg::E_HIGH - 24'd7, 1'b1, 1'b0, ghws_pkg::W_MIN);
        send_fields(ghws_pkg::E_LOW + 24'd3, 1'b1, 1'b1, '0);
        send_fields(ghws_pkg::E_LOW + 24'd3, 1'b1, 1'b1, '1);
        send_fields(ghws_pkg::E_HIGH - 24'd1, 1'b1, 1'b0, 40'sd1);

        // A large shift size pushes extreme weights into saturation.
        write_register(ghws_pkg::REG_SIGMA, 32'h7FFF_FFFF);
        send_fields(24'd327680, 1'b1, 1'b1, ghws_pkg::W_MAX);
        send_fields(24'd327680, 1'b1, 1'b1, ghws_pkg::W_MIN);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            sig = (ph == 6) ? $urandom : phase_sigma[ph];
            write_register(ghws_pkg::REG_BEAM_MODE, ghws_pkg::PDATA_W'(phase_beam[ph]));
            write_register(ghws_pkg::REG_SIGMA, sig);
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 51; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 51; end
                default: begin send_idle_pct = 30; stall_pct = 30; end
            endcase
            for (int k = 0; k < PHASE_REQS; k++) begin
                // Hold the output long enough for the pipeline to back up.
                if (ph == PRESSURE_PHASE && k == 20) hold_len = HOLD_CYCLES;
                send_request(random_request());
            end
        end
        i_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Sent %0d event requests over %0d register writes, beam modes 0 to 3.",
                 n_sent, n_settings);
        $display("Checked %0d results: %0d scaled, %0d saturated, %0d errors.",
                 sb.checked, sb.applied, sb.clipped, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
